@@ rtl/core/lras_pkg.sv @@
// shared types and constants for the line rasterizer
`default_nettype none
package lras_pkg;

  localparam int COORD_BITS   = 6;
  localparam int CANVAS_BITS  = 7;
  localparam int CFG_IDX_BITS = 1;
  localparam int ERR_BITS     = COORD_BITS + 3;

  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = CANVAS_BITS'(60);
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = CANVAS_BITS'(30);

  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } lras_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  inside_res;
    logic                  last_pixel;
  } lras_out_t;

  typedef struct packed {
    logic load;
    logic step;
  } lras_cmd_t;

  typedef struct packed {
    logic last;
  } lras_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/lras_ctrl.sv @@
// controller state machine for the line rasterizer
`default_nettype none
module lras_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire lras_pkg::lras_sts_t sts,
  output lras_pkg::lras_cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/lras_dpath.sv @@
// error-term datapath and canvas registers for the line rasterizer
`default_nettype none
module lras_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [lras_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [lras_pkg::CANVAS_BITS-1:0]     cfg_data,
  input  wire lras_pkg::lras_in_t                   in_data,
  input  wire lras_pkg::lras_cmd_t                  cmd,
  output lras_pkg::lras_sts_t                       sts,
  output lras_pkg::lras_out_t                       out_data
);

  localparam int CB = lras_pkg::COORD_BITS;
  localparam int EB = lras_pkg::ERR_BITS;

  logic [lras_pkg::CANVAS_BITS-1:0] canvas_width;
  logic [lras_pkg::CANVAS_BITS-1:0] canvas_height;

  logic [CB-1:0]        cx, cy, ex, ey, dx, ady;
  logic                 sx, sy;
  logic signed [EB-1:0] err;

  logic [CB-1:0]        dx_in, dy_in;
  logic signed [EB-1:0] dx_s, dy_s, err_a, err_next;
  logic signed [EB:0]   e2;
  logic                 x_step, y_step;
  logic                 last;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= lras_pkg::CANVAS_WIDTH_RST;
      canvas_height <= lras_pkg::CANVAS_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lras_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        lras_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // endpoint deltas at load
  always_comb begin
    dx_in = (in_data.end_x > in_data.start_x) ? in_data.end_x - in_data.start_x
                                              : in_data.start_x - in_data.end_x;
    dy_in = (in_data.end_y > in_data.start_y) ? in_data.end_y - in_data.start_y
                                              : in_data.start_y - in_data.end_y;
  end

  // one bresenham step
  always_comb begin
    dx_s     = signed'(EB'(dx));
    dy_s     = -signed'(EB'(ady));
    e2       = signed'({err, 1'b0});
    x_step   = (e2 >= dy_s);
    y_step   = (e2 <= dx_s);
    err_a    = x_step ? err + dy_s : err;
    err_next = y_step ? err_a + dx_s : err_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx  <= in_data.start_x;
      cy  <= in_data.start_y;
      ex  <= in_data.end_x;
      ey  <= in_data.end_y;
      dx  <= dx_in;
      ady <= dy_in;
      sx  <= (in_data.start_x < in_data.end_x);
      sy  <= (in_data.start_y < in_data.end_y);
      err <= signed'(EB'(dx_in)) - signed'(EB'(dy_in));
    end else if (cmd.step) begin
      err <= err_next;
      if (x_step) begin
        cx <= sx ? cx + CB'(1) : cx - CB'(1);
      end
      if (y_step) begin
        cy <= sy ? cy + CB'(1) : cy - CB'(1);
      end
    end
  end

  assign last     = (cx == ex) && (cy == ey);
  assign sts.last = last;

  always_comb begin
    out_data.pixel_x    = cx;
    out_data.pixel_y    = cy;
    out_data.inside_res = (lras_pkg::CANVAS_BITS'(cx) < canvas_width) &&
                          (lras_pkg::CANVAS_BITS'(cy) < canvas_height);
    out_data.last_pixel = last;
  end

endmodule
`default_nettype wire

@@ rtl/core/line_rasterizer.sv @@
// top level of the bresenham line rasterizer
`default_nettype none
// Accepts one line request (two endpoints) when idle and emits its pixels from
// start to end, one per cycle while out_ready is high, the final one flagged
// last_pixel. A line of max(|dx|,|dy|)+1 pixels is taken in with a load step and
// then holds the block until its last pixel is taken; the single error-term update
// step sets the one-pixel-per-cycle pace. inside_res compares each pixel with the canvas
// width and height registers, which are written through the cfg port.
module line_rasterizer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lras_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [lras_pkg::CANVAS_BITS-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire lras_pkg::lras_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output lras_pkg::lras_out_t                    out_data
);

  lras_pkg::lras_cmd_t cmd;
  lras_pkg::lras_sts_t sts;

  lras_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lras_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no pixel after accepted request");

  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_pixel) |=> in_ready)
    else $error("not idle after last pixel");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data.pixel_x) && $stable(out_data.pixel_y))
    else $error("pixel moved while stalled");

endmodule
`default_nettype wire

@@ tb/lras_checker.sv @@
// line rasterizer checker: predicts the pixels of each line request and compares results
`timescale 1ns / 100ps
module lras_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lras_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lras_pkg::CANVAS_BITS-1:0]  cfg_data,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  lras_pkg::lras_in_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  lras_pkg::lras_out_t               out_data,
  output int                                fail_count,
  output int                                pending
);

  localparam int CB = lras_pkg::COORD_BITS;

  lras_pkg::lras_out_t              pixel_q[$];
  logic [lras_pkg::CANVAS_BITS-1:0] width_reg;
  logic [lras_pkg::CANVAS_BITS-1:0] height_reg;

  task automatic plot_line(input lras_pkg::lras_in_t req);
    int cx, cy, ex, ey, dx, dy, sx, sy, err, e2, n;
    bit done;
    lras_pkg::lras_out_t px;
    cx = int'(req.start_x);
    cy = int'(req.start_y);
    ex = int'(req.end_x);
    ey = int'(req.end_y);
    dx = (ex > cx) ? ex - cx : cx - ex;
    dy = (ey > cy) ? cy - ey : ey - cy;
    sx = (cx < ex) ? 1 : -1;
    sy = (cy < ey) ? 1 : -1;
    err = dx + dy;
    n = 0;
    done = 1'b0;
    while (!done && n < (1 << CB)) begin
      done = (cx == ex) && (cy == ey);
      px.pixel_x    = cx[CB-1:0];
      px.pixel_y    = cy[CB-1:0];
      px.inside_res = (cx < int'(width_reg)) && (cy < int'(height_reg));
      px.last_pixel = done;
      pixel_q = {pixel_q, px};
      n++;
      if (!done) begin
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          cx += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          cy += sy;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [CB-1:0] want,
                             input logic [CB-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lras_pkg::lras_out_t want_px;
    if (rst) begin
      width_reg = lras_pkg::CANVAS_WIDTH_RST;
      height_reg = lras_pkg::CANVAS_HEIGHT_RST;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lras_pkg::REG_CANVAS_WIDTH:  width_reg = cfg_data;
          lras_pkg::REG_CANVAS_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel with no pending line: x=%0d y=%0d",
                 out_data.pixel_x, out_data.pixel_y);
          fail_count++;
        end else begin
          want_px = pixel_q.pop_front();
          check_field("pixel_x", want_px.pixel_x, out_data.pixel_x);
          check_field("pixel_y", want_px.pixel_y, out_data.pixel_y);
          check_field("inside_res", CB'(want_px.inside_res),
                      CB'(out_data.inside_res));
          check_field("last_pixel", CB'(want_px.last_pixel),
                      CB'(out_data.last_pixel));
        end
      end
      if (in_valid && in_ready) begin
        plot_line(in_data);
      end
    end
    pending = pixel_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// line rasterizer testbench top: clock, reset, line requests, canvas writes and verdict
`timescale 1ns / 100ps
module tb_top;
  import lras_pkg::*;

  localparam int LONG_HOLD = 300;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CANVAS_BITS-1:0]  cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  lras_in_t                in_data;
  logic                    out_valid;
  logic                    out_ready;
  lras_out_t               out_data;
  int                      fail_count;
  int                      pending;
  bit                      gaps_on = 1'b1;
  bit                      stall_on = 1'b1;
  bit                      long_hold_req = 1'b0;

  always #5 clk = ~clk;

  line_rasterizer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lras_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < 0) return '0;
    if (v > (1 << COORD_BITS) - 1) return '1;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic lras_in_t make_line(input int x0, input int y0, input int x1,
                                         input int y1);
    lras_in_t r;
    r.start_x = clamp_coord(x0);
    r.start_y = clamp_coord(y0);
    r.end_x   = clamp_coord(x1);
    r.end_y   = clamp_coord(y1);
    return r;
  endfunction

  // short lines most often, some long ones, axis, diagonal and single points
  function automatic lras_in_t random_line();
    int kind, x0, y0, d;
    kind = $urandom_range(0, 9);
    x0 = $urandom_range(0, 63);
    y0 = $urandom_range(0, 63);
    d = $urandom_range(0, 63);
    case (kind)
      0, 1, 2: return make_line(x0, y0, $urandom_range(0, 63), $urandom_range(0, 63));
      3, 4, 5, 6: return make_line(x0, y0, x0 + int'($urandom_range(0, 12)) - 6,
                                   y0 + int'($urandom_range(0, 12)) - 6);
      7: begin
        if ($urandom_range(0, 1)) return make_line(x0, y0, $urandom_range(0, 63), y0);
        return make_line(x0, y0, x0, $urandom_range(0, 63));
      end
      8: begin
        if ($urandom_range(0, 1)) return make_line(x0, y0, x0 + d, y0 - d);
        return make_line(x0, y0, x0 - d, y0 + d);
      end
      default: return make_line(x0, y0, x0, y0);
    endcase
  endfunction

  task automatic send_line(input lras_in_t req);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_line(random_line());
    end
  endtask

  // sender stops until every pending pixel has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CANVAS_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    write_reg(REG_CANVAS_WIDTH, w[CANVAS_BITS-1:0]);
    write_reg(REG_CANVAS_HEIGHT, h[CANVAS_BITS-1:0]);
  endtask

  initial begin : rx_side
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
  end

  initial begin : stim
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single points, full-length axes and diagonals, all octants, canvas edge
    send_line(make_line(0, 0, 0, 0));
    send_line(make_line(63, 63, 63, 63));
    send_line(make_line(0, 0, 63, 0));
    send_line(make_line(63, 0, 0, 0));
    send_line(make_line(0, 0, 0, 63));
    send_line(make_line(0, 63, 0, 0));
    send_line(make_line(0, 0, 63, 63));
    send_line(make_line(63, 63, 0, 0));
    send_line(make_line(63, 0, 0, 63));
    send_line(make_line(0, 63, 63, 0));
    send_line(make_line(10, 10, 20, 13));
    send_line(make_line(10, 10, 13, 20));
    send_line(make_line(10, 10, 0, 13));
    send_line(make_line(10, 10, 7, 20));
    send_line(make_line(10, 10, 0, 7));
    send_line(make_line(10, 10, 7, 0));
    send_line(make_line(10, 10, 20, 7));
    send_line(make_line(10, 10, 13, 0));
    send_line(make_line(57, 27, 62, 33));
    send_line(make_line(0, 5, 63, 6));

    drain();
    set_canvas(0, 64);
    send_random(14);

    // receiver blocked for a long stretch while requests keep coming
    drain();
    set_canvas(64, 0);
    long_hold_req = 1'b1;
    send_random(14);

    drain();
    set_canvas(127, 127);
    send_random(14);

    drain();
    set_canvas(1, 1);
    send_random(14);

    drain();
    set_canvas($urandom_range(1, 64), $urandom_range(1, 64));
    send_random(14);

    drain();
    set_canvas(60, 30);
    gaps_on = 1'b0;
    stall_on = 1'b0;
    send_random(16);

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
